@@ sv/hash_table_linear_probe_core_macros.svh @@
// ============================================================================
// Assertion macros for the hash table core
// Concurrent checks compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef HASH_TABLE_LINEAR_PROBE_CORE_MACROS_SVH
`define HASH_TABLE_LINEAR_PROBE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define HTLP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("htlp assertion failed");

// Check that a condition leads to a consequence in the next cycle.
`define HTLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htlp assertion failed");

`else

`define HTLP_ASSERT(lbl, clk, rst_n, prop)
`define HTLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/htlp_pkg.sv @@
// ============================================================================
// htlp_pkg
// Shared types and constants of the linear-probing hash table core.
// ============================================================================
package htlp_pkg;

  // Field widths of the channels.
  localparam int KEY_PORT_W = 64;
  localparam int LEN_W      = 4;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 8;
  localparam int MAXE_W     = 9;
  localparam int HASH_W     = 32;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = MAXE_W'(192);

  // FNV-1a, 32 bit.
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

  // Request types.
  localparam logic REQ_SET = 1'b0;
  localparam logic REQ_GET = 1'b1;

  // Result codes.
  localparam logic [STATUS_W-1:0] STS_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STS_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd4;

  // Hash unit to controller.
  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] hash;
  } hash_status_t;

endpackage

@@ sv/htlp_ram.sv @@
// ============================================================================
// htlp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module htlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/htlp_hash.sv @@
// ============================================================================
// htlp_hash
// Byte-serial FNV-1a hash unit: one xor-multiply step per clock.
// ============================================================================
module htlp_hash import htlp_pkg::*; #(
  parameter int KEY_BYTES = 8,
  localparam int KEY_W = 8 * KEY_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [KEY_W-1:0]   key,
  input  logic [LEN_W-1:0]   len,
  output hash_status_t       status
);

  logic              run_r, run_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [HASH_W-1:0] h_r, h_nxt;
  logic [HASH_W-1:0] mix;
  logic              last;

  assign last = (cnt_r == len_r);
  assign mix  = h_r ^ {{(HASH_W-8){1'b0}}, key_r[7:0]};

  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    len_nxt = len_r;
    key_nxt = key_r;
    h_nxt   = h_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      len_nxt = len;
      key_nxt = key;
      h_nxt   = FNV_BASIS;
    end else if (run_r) begin
      if (last) begin
        run_nxt = 1'b0;
      end else begin
        // fold in the next byte, then shift it out
        h_nxt   = HASH_W'(mix * FNV_PRIME);
        key_nxt = key_r >> 8;
        cnt_nxt = cnt_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      len_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
    key_r <= key_nxt;
    h_r   <= h_nxt;
  end

  assign status.done = run_r && last;
  assign status.hash = h_r;

endmodule

@@ sv/hash_table_linear_probe_core.sv @@
// ============================================================================
// hash_table_linear_probe_core
// Open-addressed key/value table with FNV-1a hashing and linear probing.
// ============================================================================
// Usage:
//   Input channel (in_*): one set or get request per transfer. Keys longer
//   than KEY_BYTES saturate; bytes at or above the key length are ignored.
//   Result channel (out_*): exactly one result per request, in order.
//   Config port (APB style): register max_entries at byte address 0.
// Operation:
//   One request at a time. A request is hashed over its L key bytes, L the
//   saturated key length (one hash multiply per byte), and then probes P
//   slots (one entry-memory read per cycle, 1 to TABLE_SLOTS). A new request
//   can be taken once the result is registered.
// Reset:
//   rst_n clears the control state and the entry count and sets max_entries to 192.
//   A clearing pass then zeroes the entry memory, one slot per cycle, over
//   all TABLE_SLOTS slots; in_stall stays high meanwhile. Config writes are
//   taken at all times except while rst_n is low.
// Back pressure:
//   The result sits in an output register; while out_stall holds it, the
//   next request may still be taken and hashed and probed up to its final
//   slot, where it waits for the register to free up.
// TABLE_SLOTS must be a power of two.
// ============================================================================
`include "hash_table_linear_probe_core_macros.svh"

module hash_table_linear_probe_core import htlp_pkg::*; #(
  parameter int TABLE_SLOTS = 256,
  parameter int KEY_BYTES   = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [KEY_PORT_W-1:0] in_key_bytes,
  input  logic [LEN_W-1:0]      in_key_length,
  input  logic [VALUE_W-1:0]    in_data_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [VALUE_W-1:0]    out_read_value,
  output logic [SLOT_OUT_W-1:0] out_slot_index,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int KEY_W   = 8 * KEY_BYTES;
  localparam int ENTRY_W = 1 + LEN_W + KEY_W + VALUE_W;
  localparam int CNT_W   = ($clog2(TABLE_SLOTS + 1) > MAXE_W) ?
                           $clog2(TABLE_SLOTS + 1) : MAXE_W;

  // entry layout: {valid, length, key, value}
  localparam int VAL_LSB = 0;
  localparam int KEY_LSB = VALUE_W;
  localparam int LEN_LSB = VALUE_W + KEY_W;
  localparam int VLD_BIT = ENTRY_W - 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic                req_type_r, req_type_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [VALUE_W-1:0]  data_r, data_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    probes_r, probes_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [MAXE_W-1:0]   max_entries_r, max_entries_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;

  logic               accept;
  logic               out_free;
  logic               cfg_wr;
  logic [LEN_W-1:0]   len_sat;
  logic [KEY_W-1:0]   key_masked;
  hash_status_t       hash_st;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  logic               ent_valid;
  logic [LEN_W-1:0]   ent_len;
  logic [KEY_W-1:0]   ent_key;
  logic [VALUE_W-1:0] ent_value;
  logic               hit;
  logic               last_probe;
  logic               stop;
  logic               resolve;
  logic               room;

  // --------------------------------------------------------------------------
  // Request intake: saturate the length, drop stray key bytes.
  // --------------------------------------------------------------------------
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign len_sat  = (in_key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                        : in_key_length;

  for (genvar b = 0; b < KEY_BYTES; b++) begin : g_key_mask
    assign key_masked[8*b +: 8] = (LEN_W'(b) < len_sat) ? in_key_bytes[8*b +: 8]
                                                         : 8'h00;
  end

  htlp_hash #(
    .KEY_BYTES (KEY_BYTES)
  ) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .key    (key_masked),
    .len    (len_sat),
    .status (hash_st)
  );

  // --------------------------------------------------------------------------
  // Entry memory: one slot per word.
  // --------------------------------------------------------------------------
  htlp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ent_valid = rd_data[VLD_BIT];
  assign ent_len   = rd_data[LEN_LSB +: LEN_W];
  assign ent_key   = rd_data[KEY_LSB +: KEY_W];
  assign ent_value = rd_data[VAL_LSB +: VALUE_W];

  // The read data belongs to slot idx_r while in ST_PROBE.
  assign hit        = ent_valid && (ent_len == len_r) && (ent_key == key_r);
  assign last_probe = (probes_r == {IDX_W{1'b1}});
  assign stop       = !ent_valid || hit || last_probe;
  assign out_free   = !out_valid_r || !out_stall;
  assign resolve    = (state_r == ST_PROBE) && stop && out_free;
  assign room       = (count_r < CNT_W'(max_entries_r));

  // --------------------------------------------------------------------------
  // Configuration port.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? '0 : CFG_DATA_W'(max_entries_r);

  // --------------------------------------------------------------------------
  // Sequencer: clear, idle, hash, probe.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    req_type_nxt    = req_type_r;
    key_nxt         = key_r;
    len_nxt         = len_r;
    data_nxt        = data_r;
    idx_nxt         = idx_r;
    probes_nxt      = probes_r;
    count_nxt       = count_r;
    max_entries_nxt = cfg_wr ? pwdata[MAXE_W-1:0] : max_entries_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_value_nxt   = out_value_r;
    out_slot_nxt    = out_slot_r;
    wr_en           = 1'b0;
    wr_addr         = idx_r;
    wr_data         = {1'b1, len_r, key_r, data_r};
    rd_en           = 1'b0;
    rd_addr         = idx_r + IDX_W'(1);

    // drop the result once it has been taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + IDX_W'(1);
        if (clr_addr_r == {IDX_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_type_nxt = in_req_type;
          key_nxt      = key_masked;
          len_nxt      = len_sat;
          data_nxt     = in_data_value;
          state_nxt    = ST_HASH;
        end
      end
      ST_HASH: begin
        // start probing at the home slot
        if (hash_st.done) begin
          rd_en      = 1'b1;
          rd_addr    = hash_st.hash[IDX_W-1:0];
          idx_nxt    = hash_st.hash[IDX_W-1:0];
          probes_nxt = '0;
          state_nxt  = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!stop) begin
          // advance to the next slot, wrapping at the table end
          rd_en      = 1'b1;
          idx_nxt    = idx_r + IDX_W'(1);
          probes_nxt = probes_r + IDX_W'(1);
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_slot_nxt  = SLOT_OUT_W'(idx_r);
          state_nxt     = ST_IDLE;
          if (req_type_r == REQ_GET) begin
            if (hit) begin
              out_status_nxt = STS_FOUND;
              out_value_nxt  = ent_value;
            end else begin
              out_status_nxt = STS_NOT_FOUND;
              out_slot_nxt   = '0;
            end
          end else if (hit) begin
            // overwrite value; key and length are equal already
            wr_en          = 1'b1;
            out_status_nxt = STS_UPDATED;
          end else if (!ent_valid && room) begin
            wr_en          = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
            out_status_nxt = STS_INSERTED;
          end else begin
            out_status_nxt = STS_FULL;
            out_slot_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      probes_r      <= '0;
      count_r       <= '0;
      max_entries_r <= MAX_ENTRIES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      probes_r      <= probes_nxt;
      count_r       <= count_nxt;
      max_entries_r <= max_entries_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    req_type_r   <= req_type_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    data_r       <= data_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;
  assign out_slot_index = out_slot_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // each insert takes an empty slot, so the count never passes the table size
  `HTLP_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(TABLE_SLOTS))
  // the memory is written during probing only for a set request
  `HTLP_ASSERT(a_probe_write_set, clk, rst_n,
    !(wr_en && state_r == ST_PROBE) || req_type_r == REQ_SET)
  // an insert result goes with exactly one more occupied slot
  `HTLP_ASSERT_NEXT(a_insert_count, clk, rst_n,
    resolve && out_status_nxt == STS_INSERTED,
    count_r == $past(count_r) + CNT_W'(1))
  // a new result never overwrites one that is still held
  `HTLP_ASSERT(a_no_result_overrun, clk, rst_n, !(resolve && out_valid_r && out_stall))

endmodule
